### rtl/core/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants and types for the coalesced hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KEY_W       = 31;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 10;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             key_we;
        logic [IDX_W-1:0] key_addr;
        logic [KEY_W-1:0] key_data;
        logic             link_we;
        logic [IDX_W-1:0] link_addr;
        logic [IDX_W-1:0] link_data;
    } store_wr_t;

    typedef struct packed {
        logic             used;
        logic             link_valid;
        logic [IDX_W-1:0] link;
        logic [KEY_W-1:0] key;
    } store_rd_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
    } seq_res_t;

endpackage

### rtl/core/cht_store.sv
// ----------------------------------------------------------------------------
// cht_store
// Slot storage: keys, used marks and chain links, one read port.
// ----------------------------------------------------------------------------
module cht_store
    import cht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    output store_rd_t        rd,
    input  store_wr_t        wr
);

    logic [KEY_W-1:0]       keys_reg [TABLE_SLOTS];
    logic [IDX_W-1:0]       link_reg [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [TABLE_SLOTS-1:0] link_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            link_valid_reg <= '0;
        end
        else
        begin
            if (wr.key_we)
            begin
                used_reg[wr.key_addr] <= 1'b1;
            end
            if (wr.link_we)
            begin
                link_valid_reg[wr.link_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            keys_reg[wr.key_addr] <= wr.key_data;
        end
        if (wr.link_we)
        begin
            link_reg[wr.link_addr] <= wr.link_data;
        end
    end

    always_comb
    begin
        rd.used       = used_reg[rd_addr];
        rd.link_valid = link_valid_reg[rd_addr];
        rd.link       = link_reg[rd_addr];
        rd.key        = keys_reg[rd_addr];
    end

endmodule

### rtl/core/cht_seq.sv
// ----------------------------------------------------------------------------
// cht_seq
// Sequencer: chain walk and linear probe, one slot per cycle, shared
// key comparator and slot cursor.
// ----------------------------------------------------------------------------
module cht_seq
    import cht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    input  logic [KEY_W-1:0] key,
    output logic             busy,
    output logic [IDX_W-1:0] rd_addr,
    input  store_rd_t        rd,
    output store_wr_t        wr,
    output seq_res_t         res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHAIN = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_FIND  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] key_reg, key_next;

    logic             key_eq;
    logic [IDX_W-1:0] cur_inc;

    assign key_eq  = (rd.key == key_reg);
    assign cur_inc = (cur_reg == LAST_SLOT) ? '0 : cur_reg + 1'b1;
    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = cur_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        wr         = '0;
        wr.key_addr  = cur_reg;
        wr.key_data  = key_reg;
        wr.link_addr = last_reg;
        wr.link_data = cur_reg;
        res        = '0;
        res.slot   = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    cur_next   = IDX_W'(key % KEY_W'(TABLE_SLOTS));
                    state_next = (command == CMD_FIND) ? S_FIND : S_CHAIN;
                end
            end
            S_CHAIN:
            begin
                if (!rd.used)
                begin
                    wr.key_we  = 1'b1;
                    res.valid  = 1'b1;
                    res.status = ST_INSERTED;
                    state_next = S_IDLE;
                end
                else if (key_eq)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_DUPLICATE;
                    res.slot   = '0;
                    state_next = S_IDLE;
                end
                else if (rd.link_valid)
                begin
                    cur_next = rd.link;
                end
                else
                begin
                    last_next  = cur_reg;
                    cur_next   = cur_inc;
                    cnt_next   = IDX_W'(1);
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!rd.used)
                begin
                    wr.key_we  = 1'b1;
                    wr.link_we = 1'b1;
                    res.valid  = 1'b1;
                    res.status = ST_INSERTED;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_FULL;
                    res.slot   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIND:
            begin
                if (rd.used && key_eq)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_FOUND;
                    state_next = S_IDLE;
                end
                else if (rd.used && rd.link_valid)
                begin
                    cur_next = rd.link;
                end
                else
                begin
                    res.valid  = 1'b1;
                    res.status = ST_NOT_FOUND;
                    res.slot   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        last_reg <= last_next;
        cnt_reg  <= cnt_next;
        key_reg  <= key_next;
    end

    a_res_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after a result");

    a_no_res_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> state_reg != S_IDLE)
        else $error("result raised while idle");

    a_link_with_key: assert property (@(posedge clk) disable iff (!rst_n)
        wr.link_we |-> wr.key_we && wr.link_addr != wr.key_addr)
        else $error("link written without a key write or onto itself");

    a_insert_writes: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_INSERTED |-> wr.key_we && !rd.used)
        else $error("insert reported without storing into a free slot");

    a_write_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr.key_we |-> res.valid && res.status == ST_INSERTED)
        else $error("key stored without an insert result");

endmodule

### rtl/core/coalesced_hash_table_top.sv
// ----------------------------------------------------------------------------
// coalesced_hash_table_top
// Coalesced-chaining hash table with insert and find commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The sequencer visits
// one slot per cycle through a single read port on the slot store: an insert
// stops at an empty home slot, otherwise it walks the chain, checking for a
// duplicate, and then probes linearly for a free slot; a find walks the chain
// only. The result appears in the cycle after the last visit on status and
// slot_index with done high for exactly one cycle; the receiver cannot stall,
// and a new command may be started while done is high.
// ----------------------------------------------------------------------------
module coalesced_hash_table_top
    import cht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [KEY_W-1:0]      key,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [SLOT_OUT_W-1:0] slot_index
);

    logic [IDX_W-1:0] rd_addr;
    store_rd_t        rd;
    store_wr_t        wr;
    seq_res_t         res;

    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SLOT_OUT_W-1:0] slot_index_reg;

    cht_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd      (rd),
        .wr      (wr)
    );

    cht_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .key     (key),
        .busy    (busy),
        .rd_addr (rd_addr),
        .rd      (rd),
        .wr      (wr),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg     <= res.status;
            slot_index_reg <= SLOT_OUT_W'(res.slot);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_index_reg;

endmodule

### test/coalesced_hash_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coalesced_hash_table_top_tb
// Self-checking bench for the coalesced-chaining hash table.
// ----------------------------------------------------------------------------
// A short directed table first builds shared chains, a wrapping probe and a
// full table. Then about 1300 random insert and find beats follow, aimed at
// stored keys and at colliding small keys. Each outcome is fixed by its row or
// predicted by a mirror of the slot store, checked field by field at the done strobe.
// ----------------------------------------------------------------------------
module coalesced_hash_table_top_tb;
    import cht_pkg::*;

    localparam int RANDOM_BEATS = 1300;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
    } outcome_t;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_W-1:0]      k;
        logic                  fixed;
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  command;
    logic [KEY_W-1:0]      key;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;

    logic [KEY_W-1:0] mirror_key     [TABLE_SLOTS];
    logic             mirror_used    [TABLE_SLOTS];
    int               mirror_next    [TABLE_SLOTS];
    logic             mirror_next_ok [TABLE_SLOTS];

    outcome_t pending_outcomes[$];
    outcome_t want;
    int       mismatch_count;
    int       fail_count;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_FIND,   31'd0,          1'b1, ST_NOT_FOUND, 10'd0},
        '{CMD_INSERT, 31'd0,          1'b1, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'd0,          1'b1, ST_DUPLICATE, 10'd0},
        '{CMD_INSERT, 31'd8,          1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'd16,         1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'd1,          1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'd16,         1'b0, ST_INSERTED,  10'd0},
        '{CMD_FIND,   31'd16,         1'b0, ST_INSERTED,  10'd0},
        '{CMD_FIND,   31'd1,          1'b0, ST_INSERTED,  10'd0},
        '{CMD_FIND,   31'd24,         1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'h7FFF_FFFF,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'h7FFF_FFF7,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_FIND,   31'h7FFF_FFF7,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'h5555_5555,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'h2AAA_AAAA,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'd24,         1'b1, ST_FULL,      10'd0},
        '{CMD_INSERT, 31'h2AAA_AAAA,  1'b1, ST_DUPLICATE, 10'd0},
        '{CMD_FIND,   31'h2AAA_AAAA,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_FIND,   31'h7FFF_FFFF,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_FIND,   31'h5555_5555,  1'b0, ST_INSERTED,  10'd0},
        '{CMD_INSERT, 31'h7FFF_FFF7,  1'b1, ST_DUPLICATE, 10'd0},
        '{CMD_FIND,   31'd32,         1'b1, ST_NOT_FOUND, 10'd0},
        '{CMD_INSERT, 31'h7FFF_FFFE,  1'b1, ST_FULL,      10'd0},
        '{CMD_FIND,   31'd0,          1'b1, ST_FOUND,     10'd0}
    };

    coalesced_hash_table_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .key        (key),
        .done       (done),
        .status     (status),
        .slot_index (slot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Expected outcome of one command; updates the mirror on a successful insert.
    function automatic outcome_t lookup_or_insert(input logic cmd, input logic [KEY_W-1:0] k);
        int       home;
        int       tail;
        int       steps;
        int       probe;
        outcome_t r;
        home = int'(k % TABLE_SLOTS);
        r    = '{ST_NOT_FOUND, '0};
        if (cmd == CMD_INSERT)
        begin
            if (!mirror_used[home])
            begin
                mirror_used[home] = 1'b1;
                mirror_key[home]  = k;
                return '{ST_INSERTED, SLOT_OUT_W'(home)};
            end
            if (mirror_key[home] == k)
                return '{ST_DUPLICATE, '0};
            tail  = home;
            steps = 0;
            while (mirror_next_ok[tail] && steps < TABLE_SLOTS)
            begin
                tail = mirror_next[tail];
                steps++;
                if (mirror_key[tail] == k)
                    return '{ST_DUPLICATE, '0};
            end
            for (int i = 1; i < TABLE_SLOTS; i++)
            begin
                probe = (tail + i) % TABLE_SLOTS;
                if (!mirror_used[probe])
                begin
                    mirror_used[probe]    = 1'b1;
                    mirror_key[probe]     = k;
                    mirror_next[tail]     = probe;
                    mirror_next_ok[tail]  = 1'b1;
                    return '{ST_INSERTED, SLOT_OUT_W'(probe)};
                end
            end
            return '{ST_FULL, '0};
        end
        probe = home;
        for (steps = 0; steps <= TABLE_SLOTS; steps++)
        begin
            if (!mirror_used[probe])
                break;
            if (mirror_key[probe] == k)
                return '{ST_FOUND, SLOT_OUT_W'(probe)};
            if (!mirror_next_ok[probe])
                break;
            probe = mirror_next[probe];
        end
        return r;
    endfunction

    // Entered and left at a falling edge; start stays high if the next beat follows.
    task automatic drive_beat(input logic cmd, input logic [KEY_W-1:0] k, input bit gaps,
                              input bit fixed, input outcome_t fixed_out);
        outcome_t predicted;
        if (gaps)
        begin
            while ($urandom_range(0, 99) < 35)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start   <= 1'b1;
        command <= cmd;
        key     <= k;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predicted = lookup_or_insert(cmd, k);
        pending_outcomes.push_back(fixed ? fixed_out : predicted);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int mode;
        int s;
        mode = $urandom_range(0, 9);
        s    = $urandom_range(0, TABLE_SLOTS - 1);
        if (mode < 4 && mirror_used[s])
            return mirror_key[s];
        if (mode < 7)
            return KEY_W'($urandom_range(0, 63));
        if (mode == 7)
            return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom());
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                fail_count++;
                if (mismatch_count < 10)
                    $display("unexpected result: status=%0d slot=%0d", status, slot_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status || slot_index !== want.slot)
                begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                                 want.status, status, want.slot, slot_index);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_INSERT;
        key            = '0;
        mismatch_count = 0;
        fail_count     = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            mirror_key[i]     = '0;
            mirror_used[i]    = 1'b0;
            mirror_next[i]    = 0;
            mirror_next_ok[i] = 1'b0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            drive_beat(dir_rows[i].cmd, dir_rows[i].k, 1'b1, dir_rows[i].fixed,
                       '{dir_rows[i].status, dir_rows[i].slot});

        // beats 400..699 run back to back
        for (int i = 0; i < RANDOM_BEATS; i++)
            drive_beat($urandom_range(0, 1) ? CMD_FIND : CMD_INSERT, pick_key(),
                       !(i >= 400 && i < 700), 1'b0, '0);
        start <= 1'b0;

        waited = 0;
        while (pending_outcomes.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4 * TABLE_SLOTS + 8) @(posedge clk);
        if (pending_outcomes.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/cht_pkg.sv
rtl/core/cht_store.sv
rtl/core/cht_seq.sv
rtl/core/coalesced_hash_table_top.sv
test/coalesced_hash_table_top_tb.sv
